/* sv/tust_pkg.sv */
// ----------------------------------------------------------------------------
// tust_pkg
// shared types, constants and saturating helpers for the texture usage table
// ----------------------------------------------------------------------------
package tust_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int HANDLE_BITS = 32;
    localparam int CNT_BITS    = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_DETAILS = 2'd2;

    localparam logic [CNT_BITS-1:0] SAT_MAX = '1;

    typedef logic [CNT_BITS-1:0] t_cnt;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } t_state;

    // update strobes for the running totals
    typedef struct packed {
        logic rec;
        logic chg;
        logic uniq;
        logic lm;
        logic pr;
    } t_tot_ctl;

    typedef struct packed {
        t_cnt pr_mem;
        t_cnt lm_mem;
        t_cnt mem;
        t_cnt pr;
        t_cnt lm;
        t_cnt uniq;
        t_cnt chg;
        t_cnt rec;
    } t_totals;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == SAT_MAX) ? v : v + t_cnt'(1);
    endfunction

    function automatic t_cnt sat_add(input t_cnt a, input t_cnt b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_BITS] ? SAT_MAX : s[CNT_BITS-1:0];
    endfunction

endpackage

/* sv/tust_totals.sv */
// ----------------------------------------------------------------------------
// tust_totals
// saturating running counters and memory sums
// ----------------------------------------------------------------------------
module tust_totals
    import tust_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tot_ctl i_ctl,
    input  t_cnt     i_mem,
    output t_totals  o_tot
);

    t_totals r_tot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot <= '0;
        end else begin
            if (i_ctl.rec) begin
                r_tot.rec <= sat_inc(r_tot.rec);
            end
            if (i_ctl.chg) begin
                r_tot.chg <= sat_inc(r_tot.chg);
            end
            if (i_ctl.uniq) begin
                r_tot.uniq <= sat_inc(r_tot.uniq);
                r_tot.mem  <= sat_add(r_tot.mem, i_mem);
                if (i_ctl.lm) begin
                    r_tot.lm     <= sat_inc(r_tot.lm);
                    r_tot.lm_mem <= sat_add(r_tot.lm_mem, i_mem);
                end
                if (i_ctl.pr) begin
                    r_tot.pr     <= sat_inc(r_tot.pr);
                    r_tot.pr_mem <= sat_add(r_tot.pr_mem, i_mem);
                end
            end
        end
    end

    assign o_tot = r_tot;

endmodule

/* sv/texture_usage_stats_table_top.sv */
// ----------------------------------------------------------------------------
// texture_usage_stats_table_top
// texture use statistics with a searched table of distinct handles
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one texture use per beat; m_axis returns one result beat
//   for every input beat, in order. i_cfg_we/i_cfg_wdata set the record mode;
//   the user must write it only while the block is idle, which is not enforced.
// timing:
//   a use in mode none or with a null handle goes from idle straight to the
//   emit state and then into the output register. otherwise the table is
//   scanned one entry per cycle through a single compare on the handle memory
//   read port, over the filled entries, and stops at a match or at the end.
//   s_axis_tready is high only in the idle state, one item at a time.
// reset:
//   clears all totals, the entry count, the last handle and the mode; the
//   table memories need no clearing since only filled entries are read.
// stall:
//   a finished result waits in the output register while the next item is
//   accepted and scanned; the block holds before loading a new result until
//   the receiver takes the waiting one.
// ----------------------------------------------------------------------------
module texture_usage_stats_table_top
    import tust_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_wdata,      // record_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,     // texture_handle, memory_usage
    input  logic [1:0]   s_axis_tuser,     // lm_flag, pr_flag
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // entry_usage_count, entry_change_count, total_records, total_changes,
    // distinct_textures, lightmap_textures, procedural_textures,
    // total_memory, lightmap_memory, procedural_memory
    output logic [319:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser      // hit, table_full
);

    logic [HANDLE_BITS-1:0] mem_handle [TABLE_DEPTH];
    t_cnt                   mem_use    [TABLE_DEPTH];
    t_cnt                   mem_chg    [TABLE_DEPTH];

    t_state r_state, n_state;
    logic [1:0] r_mode;

    logic [HANDLE_BITS-1:0] r_handle, r_last_handle;
    logic                   r_lm, r_pr, r_changed;
    t_cnt                   r_mem;
    logic [USED_W-1:0]      r_used, r_rd_idx;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic                   r_cmp_vld;
    logic [HANDLE_BITS-1:0] r_rd_handle;
    t_cnt                   r_rd_use, r_rd_chg;
    logic                   r_hit, r_full;
    t_cnt                   r_use, r_chg;
    logic                   r_m_valid;
    logic [319:0]           r_m_data;
    logic [1:0]             r_m_user;

    logic [HANDLE_BITS-1:0] w_in_handle;
    logic w_accept, w_changed, w_bypass, w_details;
    logic w_match, w_scan_end, w_room, w_emit_load;
    logic w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    t_cnt w_hit_use, w_hit_chg, w_wr_use, w_wr_chg;
    t_tot_ctl w_tot_ctl;
    t_totals  w_tot;

    assign w_in_handle = s_axis_tdata[HANDLE_BITS-1:0];
    assign w_accept    = s_axis_tvalid & s_axis_tready;
    assign w_changed   = (w_in_handle != r_last_handle);
    assign w_bypass    = (r_mode == MODE_NONE) || (w_in_handle == '0);
    assign w_details   = (r_mode == MODE_DETAILS);
    assign w_match     = r_cmp_vld && (r_rd_handle == r_handle);
    assign w_scan_end  = (r_rd_idx == r_used);
    assign w_room      = (r_used != USED_W'(TABLE_DEPTH));
    assign w_emit_load = (r_state == ST_EMIT) && (!r_m_valid || m_axis_tready);

    assign w_hit_use = w_details ? sat_inc(r_rd_use) : r_rd_use;
    assign w_hit_chg = (w_details && r_changed) ? sat_inc(r_rd_chg) : r_rd_chg;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_bypass ? ST_EMIT : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_match || w_scan_end) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready  = 1'b0;
        w_tot_ctl      = '0;
        w_wr_en        = 1'b0;
        w_wr_addr      = r_used[IDX_W-1:0];
        w_wr_use       = t_cnt'(1);
        w_wr_chg       = t_cnt'(1);
        w_tot_ctl.rec  = w_accept;
        w_tot_ctl.chg  = w_accept & w_changed;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_SEARCH: begin
                if (w_match) begin
                    w_wr_en   = w_details;
                    w_wr_addr = r_cmp_idx;
                    w_wr_use  = w_hit_use;
                    w_wr_chg  = w_hit_chg;
                end else if (w_scan_end) begin
                    w_wr_en        = w_room;
                    w_tot_ctl.uniq = 1'b1;
                    w_tot_ctl.lm   = r_lm;
                    w_tot_ctl.pr   = r_pr;
                end
            end
            ST_EMIT: begin
                s_axis_tready = 1'b0;
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_handle[w_wr_addr] <= r_handle;
            mem_use[w_wr_addr]    <= w_wr_use;
            mem_chg[w_wr_addr]    <= w_wr_chg;
        end
        r_rd_handle <= mem_handle[r_rd_idx[IDX_W-1:0]];
        r_rd_use    <= mem_use[r_rd_idx[IDX_W-1:0]];
        r_rd_chg    <= mem_chg[r_rd_idx[IDX_W-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_NONE;
            r_last_handle <= '0;
            r_used        <= '0;
            r_cmp_vld     <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_last_handle <= w_bypass ? '0 : w_in_handle;
                r_cmp_vld     <= 1'b0;
            end else if (r_state == ST_SEARCH) begin
                r_cmp_vld <= !w_scan_end;
                if (!w_match && w_scan_end && w_room) begin
                    r_used <= r_used + USED_W'(1);
                end
            end
            if (w_emit_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // item payload and scan pointer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_handle  <= w_in_handle;
            r_lm      <= s_axis_tuser[0];
            r_pr      <= s_axis_tuser[1];
            r_mem     <= s_axis_tdata[63:32];
            r_changed <= w_changed;
            r_rd_idx  <= '0;
            r_hit     <= 1'b0;
            r_full    <= 1'b0;
            r_use     <= '0;
            r_chg     <= '0;
        end else if (r_state == ST_SEARCH) begin
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
            if (!w_scan_end) begin
                r_rd_idx <= r_rd_idx + USED_W'(1);
            end
            if (w_match) begin
                r_hit <= 1'b1;
                r_use <= w_hit_use;
                r_chg <= w_hit_chg;
            end else if (w_scan_end) begin
                if (w_room) begin
                    r_use <= t_cnt'(1);
                    r_chg <= t_cnt'(1);
                end else begin
                    r_full <= 1'b1;
                end
            end
        end
        if (w_emit_load) begin
            r_m_user <= {r_full, r_hit};
            r_m_data <= {w_tot.pr_mem, w_tot.lm_mem, w_tot.mem, w_tot.pr, w_tot.lm,
                         w_tot.uniq, w_tot.chg, w_tot.rec, r_chg, r_use};
        end
    end

    tust_totals u_totals (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_tot_ctl),
        .i_mem   (r_mem),
        .o_tot   (w_tot)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the texture usage statistics table: a queued driver
// and a monitor with random idling, a behavioral predictor of the table and
// running totals, and a field-by-field check of every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import tust_pkg::*;

    localparam logic [1:0] MODE_SIMPLE = 2'd1;
    localparam logic [1:0] MODE_ALIAS  = 2'd3;
    localparam int         STALL_LIMIT = 5000;
    localparam int         MAX_REPORTS = 10;

    typedef struct {
        logic [HANDLE_BITS-1:0] hdl;
        logic                   lmap;
        logic                   procgen;
        t_cnt                   mem;
    } t_tex_use;

    typedef struct {
        logic    hit;
        logic    full;
        t_cnt    use_n;
        t_cnt    chg_n;
        t_totals tot;
    } t_use_stats;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_we      = 1'b0;
    logic [1:0]   i_cfg_wdata   = 2'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata  = '0;   // texture_handle, memory_usage
    logic [1:0]   s_axis_tuser  = '0;   // lm_flag, pr_flag
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // entry_usage_count, entry_change_count, total_records, total_changes,
    // distinct_textures, lightmap_textures, procedural_textures,
    // total_memory, lightmap_memory, procedural_memory
    logic [319:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;         // hit, table_full

    texture_usage_stats_table_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state
    logic [HANDLE_BITS-1:0] tab_hdl [TABLE_DEPTH];
    t_cnt                   tab_use [TABLE_DEPTH];
    t_cnt                   tab_chg [TABLE_DEPTH];
    int                     tab_fill = 0;
    logic [HANDLE_BITS-1:0] last_hdl = '0;
    t_totals                totals   = '0;
    logic [1:0]             rec_mode = MODE_NONE;

    t_tex_use               pend_q [$];
    t_use_stats             stats_q [$];
    logic [HANDLE_BITS-1:0] handles_seen [$];
    logic [HANDLE_BITS-1:0] prev_hdl = '0;
    t_tex_use               cur_use;
    int                     n_queued = 0;
    int                     n_taken  = 0;
    int                     n_bad    = 0;
    int                     quiet_cycles = 0;
    bit                     quiet    = 1'b0;

    string fld_name [12] = '{"entry_usage_count", "entry_change_count", "total_records",
                             "total_changes", "distinct_textures", "lightmap_textures",
                             "procedural_textures", "total_memory", "lightmap_memory",
                             "procedural_memory", "hit", "table_full"};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_cnt cnt_up(input t_cnt v);
        return (v == '1) ? v : v + t_cnt'(1);
    endfunction

    function automatic t_cnt cnt_add(input t_cnt a, input t_cnt b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_BITS] ? '1 : s[CNT_BITS-1:0];
    endfunction

    function automatic t_use_stats predict_use(input t_tex_use u);
        t_use_stats r;
        logic       changed;
        logic       found;
        int         idx;
        r       = '{hit: 1'b0, full: 1'b0, use_n: '0, chg_n: '0, tot: '0};
        changed = (u.hdl != last_hdl);
        found   = 1'b0;
        idx     = 0;
        totals.rec = cnt_up(totals.rec);
        if (changed) totals.chg = cnt_up(totals.chg);
        if (rec_mode == MODE_NONE || u.hdl == '0) begin
            last_hdl = '0;
        end else begin
            for (int i = 0; i < tab_fill; i++) begin
                if (!found && tab_hdl[i] == u.hdl) begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            if (found) begin
                if (rec_mode == MODE_DETAILS) begin
                    tab_use[idx] = cnt_up(tab_use[idx]);
                    if (changed) tab_chg[idx] = cnt_up(tab_chg[idx]);
                end
                r.hit   = 1'b1;
                r.use_n = tab_use[idx];
                r.chg_n = tab_chg[idx];
            end else begin
                if (tab_fill < TABLE_DEPTH) begin
                    tab_hdl[tab_fill] = u.hdl;
                    tab_use[tab_fill] = t_cnt'(1);
                    tab_chg[tab_fill] = t_cnt'(1);
                    tab_fill++;
                    r.use_n = t_cnt'(1);
                    r.chg_n = t_cnt'(1);
                end else begin
                    r.full = 1'b1;
                end
                totals.uniq = cnt_up(totals.uniq);
                totals.mem  = cnt_add(totals.mem, u.mem);
                if (u.lmap) begin
                    totals.lm     = cnt_up(totals.lm);
                    totals.lm_mem = cnt_add(totals.lm_mem, u.mem);
                end
                if (u.procgen) begin
                    totals.pr     = cnt_up(totals.pr);
                    totals.pr_mem = cnt_add(totals.pr_mem, u.mem);
                end
            end
            last_hdl = u.hdl;
        end
        r.tot = totals;
        return r;
    endfunction

    function automatic bit idle_now();
        return !quiet && ($urandom_range(0, 99) < 10);
    endfunction

    task automatic flag_miss(input string what, input t_cnt want, input t_cnt got);
        if (n_bad < MAX_REPORTS)
            $display("%0t: %s expected %08h actual %08h", $time, what, want, got);
        n_bad++;
    endtask

    task automatic check_beat();
        t_use_stats          want;
        logic [321:0]        wv;
        logic [321:0]        gv;
        t_cnt                want_f;
        t_cnt                got_f;
        if (stats_q.size() == 0) begin
            flag_miss("result beat with no pending use", '0, m_axis_tdata[31:0]);
        end else begin
            want = stats_q.pop_front();
            wv   = {want.full, want.hit, want.tot, want.chg_n, want.use_n};
            gv   = {m_axis_tuser, m_axis_tdata};
            for (int k = 0; k < 12; k++) begin
                if (k < 10) begin
                    want_f = wv[32*k +: 32];
                    got_f  = gv[32*k +: 32];
                end else begin
                    want_f = t_cnt'(wv[310 + k]);
                    got_f  = t_cnt'(gv[310 + k]);
                end
                if (want_f !== got_f) flag_miss(fld_name[k], want_f, got_f);
            end
        end
    endtask

    // driver: one beat held until taken, prediction at the handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                stats_q.push_back(predict_use(cur_use));
                n_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pend_q.size() != 0 && !idle_now()) begin
                    cur_use = pend_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_use.mem, cur_use.hdl};
                    s_axis_tuser  <= {cur_use.procgen, cur_use.lmap};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !idle_now();
            if (m_axis_tvalid && m_axis_tready) check_beat();
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic put(input logic [HANDLE_BITS-1:0] hdl, input logic lmap,
                       input logic procgen, input t_cnt mem);
        t_tex_use u;
        u.hdl     = hdl;
        u.lmap    = lmap;
        u.procgen = procgen;
        u.mem     = mem;
        pend_q.push_back(u);
        n_queued++;
        if (hdl != '0) handles_seen.push_back(hdl);
        prev_hdl = hdl;
    endtask

    // mix of null, new, repeated and revisited handles
    task automatic queue_random(input int count, input int pct_new, input bit heavy_mem);
        int                     r;
        logic [HANDLE_BITS-1:0] h;
        t_cnt                   mem;
        for (int n = 0; n < count; n++) begin
            r   = $urandom_range(0, 99);
            mem = $urandom;
            if (r < 6) begin
                h = '0;
            end else if (r < 6 + pct_new || handles_seen.size() == 0) begin
                do h = $urandom; while (h == '0);
                if (!heavy_mem) mem = $urandom_range(0, 4095);
            end else if (r < 26 + pct_new) begin
                h = prev_hdl;
            end else begin
                h = handles_seen[$urandom_range(0, handles_seen.size() - 1)];
            end
            put(h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), mem);
        end
    endtask

    task automatic drain();
        while (n_taken != n_queued || stats_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        drain();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rec_mode = m;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_mode(MODE_NONE);
        put('0, 1'b0, 1'b0, '0);
        put('1, 1'b1, 1'b1, '1);
        put('1, 1'b1, 1'b1, '1);
        put(32'h5, 1'b0, 1'b1, 32'h1234);

        set_mode(MODE_DETAILS);
        put('0, 1'b0, 1'b0, '1);
        put('1, 1'b1, 1'b0, '0);
        put('1, 1'b0, 1'b0, '1);
        put(32'h1, 1'b0, 1'b1, 32'd1000);
        put('1, 1'b1, 1'b1, '1);
        put('0, 1'b1, 1'b1, '1);
        put('1, 1'b0, 1'b0, '0);
        put(32'h8000_0000, 1'b1, 1'b1, 32'h0001_0000);
        put(32'h8000_0000, 1'b0, 1'b0, '1);

        set_mode(MODE_SIMPLE);
        put(32'h1, 1'b0, 1'b0, '1);
        put(32'h2, 1'b1, 1'b0, 32'd77);
        put(32'h2, 1'b0, 1'b0, '0);
        put('1, 1'b0, 1'b1, '1);

        set_mode(MODE_ALIAS);
        put(32'h1, 1'b1, 1'b0, '1);
        put(32'h3, 1'b0, 1'b0, 32'd5);
        put(32'h3, 1'b1, 1'b1, '1);

        set_mode(MODE_DETAILS);
        queue_random(400, 30, 1'b0);
        set_mode(MODE_NONE);
        queue_random(100, 20, 1'b0);
        set_mode(MODE_SIMPLE);
        queue_random(200, 20, 1'b0);
        set_mode(MODE_DETAILS);
        quiet = 1'b1;
        queue_random(300, 25, 1'b0);
        set_mode(MODE_ALIAS);
        quiet = 1'b0;
        queue_random(100, 20, 1'b0);
        // new handles in this batch overflow the table; large sizes drive the memory sums to saturation
        set_mode(MODE_DETAILS);
        queue_random(250, 30, 1'b1);

        drain();
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
